>>> hw/rtl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Types and constants shared by the indexed max-heap block.
// ----------------------------------------------------------------------------
package imh_pkg;

   localparam int ID_BITS   = 10;
   localparam int KEY_BITS  = 32;
   localparam int SLOT_BITS = 11;
   localparam int MAX_IDS   = 1 << ID_BITS;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_CHANGE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_PRESENT = 2'd3;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [KEY_BITS-1:0] key;
   } heap_entry_type;

endpackage

>>> hw/rtl/imh_if.sv
// ----------------------------------------------------------------------------
// imh request and response channels
// Valid/ready channels carrying heap requests and their responses.
// ----------------------------------------------------------------------------
interface imh_req_if import imh_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          opcode;
   logic [ID_BITS-1:0]  item_id;
   logic [KEY_BITS-1:0] item_key;
   modport source (output valid, output opcode, output item_id, output item_key, input ready);
   modport sink   (input valid, input opcode, input item_id, input item_key, output ready);
endinterface

interface imh_rsp_if import imh_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ID_BITS-1:0]   out_id;
   logic [KEY_BITS-1:0]  out_key;
   logic [1:0]           status;
   logic [SLOT_BITS-1:0] entries;
   modport source (output valid, output out_id, output out_key, output status,
                   output entries, input ready);
   modport sink   (input valid, input out_id, input out_key, input status,
                   input entries, output ready);
endinterface

>>> hw/rtl/indexed_max_heap.sv
// ----------------------------------------------------------------------------
// indexed_max_heap
// Indexed binary max-heap of 1024 ids with push, pop-max and decrease-key.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request (opcode, item_id, item_key); rsp_ch returns
//   exactly one response per request (out_id, out_key, status, entries).
//   One request is in work at a time; req_ch.ready is high only when idle.
//   The sift loop does one heap-memory write per level, reading one parent
//   (sift up) or two children (sift down) for the next level.
//   The response sits in an output register; while rsp_ch stalls, the next
//   request is accepted and worked, and it waits for the register to free.
//   After reset a clearing pass writes all 1024 slot-index entries to zero,
//   one per cycle; ready stays low until the pass is done.
//   Key and heap memories hold no reset value; the heap never uses an entry
//   it has not written.
// ----------------------------------------------------------------------------
module indexed_max_heap
   import imh_pkg::*;
(
   input logic       clock,
   input logic       reset,
   imh_req_if.sink   req_ch,
   imh_rsp_if.source rsp_ch
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_LOOK  = 7'b0000100,
      S_UP    = 7'b0001000,
      S_DOWN  = 7'b0010000,
      S_PLACE = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [ID_BITS-1:0]   cnt_ff, cnt_in;
   logic [1:0]           op_ff, op_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [SLOT_BITS-1:0] size_ff, size_in;
   logic [SLOT_BITS-1:0] s_ff, s_in;
   heap_entry_type       e_ff, e_in;
   logic [ID_BITS-1:0]   rid_ff, rid_in;
   logic [KEY_BITS-1:0]  rkey_ff, rkey_in;
   logic [1:0]           rst_ff, rst_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]   rsp_id_ff, rsp_id_in;
   logic [KEY_BITS-1:0]  rsp_key_ff, rsp_key_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [SLOT_BITS-1:0] rsp_entries_ff, rsp_entries_in;

   logic [KEY_BITS-1:0]  key_mem  [MAX_IDS];
   logic [SLOT_BITS-1:0] slot_mem [MAX_IDS];
   heap_entry_type       heap_mem [MAX_IDS];

   logic                 ko_we, so_we, hp_we;
   logic [ID_BITS-1:0]   ko_wa, so_wa, hp_wa;
   logic [KEY_BITS-1:0]  ko_wd;
   logic [SLOT_BITS-1:0] so_wd;
   heap_entry_type       hp_wd;
   logic [ID_BITS-1:0]   ko_ra, so_ra, hp_ra_a, hp_ra_b;
   logic [KEY_BITS-1:0]  ko_rd_ff;
   logic [SLOT_BITS-1:0] so_rd_ff;
   heap_entry_type       hp_rd_a_ff, hp_rd_b_ff;

   logic [SLOT_BITS-1:0] size_m1, s_m1, push_s, up_p;
   logic [SLOT_BITS:0]   left, size_x, cslot, lchg, lc;
   logic                 rsel;
   heap_entry_type       child;

   always_ff @(posedge clock) begin
      if (ko_we) key_mem[ko_wa] <= ko_wd;
      ko_rd_ff <= key_mem[ko_ra];
   end

   always_ff @(posedge clock) begin
      if (so_we) slot_mem[so_wa] <= so_wd;
      so_rd_ff <= slot_mem[so_ra];
   end

   always_ff @(posedge clock) begin
      if (hp_we) heap_mem[hp_wa] <= hp_wd;
      hp_rd_a_ff <= heap_mem[hp_ra_a];
      hp_rd_b_ff <= heap_mem[hp_ra_b];
   end

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.out_id  = rsp_id_ff;
   assign rsp_ch.out_key = rsp_key_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.entries = rsp_entries_ff;

   assign size_m1 = size_ff - 11'd1;
   assign s_m1    = s_ff - 11'd1;
   assign push_s  = size_ff + 11'd1;
   assign up_p    = s_ff >> 1;
   assign size_x  = {1'b0, size_ff};
   assign left    = {s_ff, 1'b0};
   assign rsel    = ((left + 12'd1) <= size_x) && (hp_rd_b_ff.key > hp_rd_a_ff.key);
   assign child   = rsel ? hp_rd_b_ff : hp_rd_a_ff;
   assign cslot   = rsel ? (left + 12'd1) : left;
   assign lchg    = {so_rd_ff, 1'b0};
   assign lc      = {cslot[SLOT_BITS-1:0], 1'b0};

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      key_in         = key_ff;
      size_in        = size_ff;
      s_in           = s_ff;
      e_in           = e_ff;
      rid_in         = rid_ff;
      rkey_in        = rkey_ff;
      rst_in         = rst_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_entries_in = rsp_entries_ff;
      ko_we = 1'b0; ko_wa = id_ff; ko_wd = key_ff;
      so_we = 1'b0; so_wa = id_ff; so_wd = '0;
      hp_we = 1'b0; hp_wa = s_m1[ID_BITS-1:0]; hp_wd = e_ff;
      ko_ra   = req_ch.item_id;
      so_ra   = req_ch.item_id;
      hp_ra_a = '0;
      hp_ra_b = size_m1[ID_BITS-1:0];

      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            so_we  = 1'b1;
            so_wa  = cnt_ff;
            cnt_in = cnt_ff + 10'd1;
            if (cnt_ff == ID_BITS'(MAX_IDS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.opcode;
               id_in    = req_ch.item_id;
               key_in   = req_ch.item_key;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            rid_in   = id_ff;
            rkey_in  = '0;
            rst_in   = ST_OK;
            state_in = S_DONE;
            unique case (op_ff)
               OP_PUSH: begin
                  if (size_ff >= SLOT_BITS'(MAX_IDS)) begin
                     rst_in  = ST_FULL;
                     rkey_in = ko_rd_ff;
                  end else if (so_rd_ff != '0) begin
                     rst_in  = ST_PRESENT;
                     rkey_in = ko_rd_ff;
                  end else begin
                     ko_we    = 1'b1;
                     rkey_in  = key_ff;
                     size_in  = push_s;
                     s_in     = push_s;
                     e_in     = '{id: id_ff, key: key_ff};
                     hp_ra_a  = ID_BITS'((push_s >> 1) - 11'd1);
                     state_in = (push_s == 11'd1) ? S_PLACE : S_UP;
                  end
               end
               OP_POP: begin
                  if (size_ff == '0) begin
                     rst_in = ST_EMPTY;
                     rid_in = '0;
                  end else begin
                     rid_in  = hp_rd_a_ff.id;
                     rkey_in = hp_rd_a_ff.key;
                     so_we   = 1'b1;
                     so_wa   = hp_rd_a_ff.id;
                     so_wd   = '0;
                     size_in = size_m1;
                     if (size_ff > 11'd1) begin
                        e_in     = hp_rd_b_ff;
                        s_in     = 11'd1;
                        hp_ra_a  = 10'd1;
                        hp_ra_b  = 10'd2;
                        state_in = S_DOWN;
                     end
                  end
               end
               OP_CHANGE: begin
                  ko_we   = 1'b1;
                  rkey_in = key_ff;
                  if (so_rd_ff != '0) begin
                     e_in     = '{id: id_ff, key: key_ff};
                     s_in     = so_rd_ff;
                     hp_ra_a  = ID_BITS'(lchg - 12'd1);
                     hp_ra_b  = lchg[ID_BITS-1:0];
                     state_in = S_DOWN;
                  end
               end
               default: ;
            endcase
         end
         S_UP: begin
            if (hp_rd_a_ff.key > e_ff.key) begin
               state_in = S_PLACE;
            end else begin
               hp_we   = 1'b1;
               hp_wd   = hp_rd_a_ff;
               so_we   = 1'b1;
               so_wa   = hp_rd_a_ff.id;
               so_wd   = s_ff;
               s_in    = up_p;
               hp_ra_a = ID_BITS'((up_p >> 1) - 11'd1);
               if (up_p == 11'd1) state_in = S_PLACE;
            end
         end
         S_DOWN: begin
            if (left > size_x || !(child.key > e_ff.key)) begin
               state_in = S_PLACE;
            end else begin
               hp_we   = 1'b1;
               hp_wd   = child;
               so_we   = 1'b1;
               so_wa   = child.id;
               so_wd   = s_ff;
               s_in    = cslot[SLOT_BITS-1:0];
               hp_ra_a = ID_BITS'(lc - 12'd1);
               hp_ra_b = lc[ID_BITS-1:0];
            end
         end
         S_PLACE: begin
            hp_we    = 1'b1;
            hp_wd    = e_ff;
            so_we    = 1'b1;
            so_wa    = e_ff.id;
            so_wd    = s_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_id_in      = rid_ff;
               rsp_key_in     = rkey_ff;
               rsp_status_in  = rst_ff;
               rsp_entries_in = size_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      id_ff          <= id_in;
      key_ff         <= key_in;
      s_ff           <= s_in;
      e_ff           <= e_in;
      rid_ff         <= rid_in;
      rkey_ff        <= rkey_in;
      rst_ff         <= rst_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_entries_ff <= rsp_entries_in;
   end

endmodule

>>> hw/rtl/imh_checker.sv
// ----------------------------------------------------------------------------
// imh_checker
// Port-level checks for the indexed max-heap, bound to the top level.
// ----------------------------------------------------------------------------
module imh_checker
   import imh_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ID_BITS-1:0]   rsp_out_id,
   input logic [KEY_BITS-1:0]  rsp_out_key,
   input logic [1:0]           rsp_status,
   input logic [SLOT_BITS-1:0] rsp_entries
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_id) && $stable(rsp_out_key)
                                  && $stable(rsp_status) && $stable(rsp_entries))
      else $error("response payload changed while stalled");

   a_entries_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entries <= SLOT_BITS'(MAX_IDS))
      else $error("entries beyond capacity");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_entries == '0 && rsp_out_id == '0)
      else $error("pop on empty with nonempty heap");

   a_clear_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during clearing pass");

endmodule

bind indexed_max_heap imh_checker u_imh_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_out_id  (rsp_ch.out_id),
   .rsp_out_key (rsp_ch.out_key),
   .rsp_status  (rsp_ch.status),
   .rsp_entries (rsp_ch.entries)
);

>>> tb/sv/indexed_max_heap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_max_heap_tb
// Drives push, pop-max, decrease-key and unused-opcode requests into the indexed
// max-heap, keeps a shadow heap of its own, and checks every response field in order.
// ----------------------------------------------------------------------------
module indexed_max_heap_tb;
   import imh_pkg::*;

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [KEY_BITS-1:0]  key;
      logic [1:0]           status;
      logic [SLOT_BITS-1:0] entries;
   } heap_rsp_type;

   class heap_scoreboard;
      logic [KEY_BITS-1:0]  key_tab [MAX_IDS];
      logic [ID_BITS-1:0]   slot_tab [MAX_IDS];
      int                   pos_tab [MAX_IDS];
      int                   count;
      heap_rsp_type         pending [$];
      int                   errors;
      int                   checked;

      function new();
         for (int i = 0; i < MAX_IDS; i++) begin
            key_tab[i] = '0;
            slot_tab[i] = '0;
            pos_tab[i] = 0;
         end
         count = 0;
         errors = 0;
         checked = 0;
      endfunction

      function logic [KEY_BITS-1:0] key_in(int s);
         return key_tab[slot_tab[s-1]];
      endfunction

      function void place(int s, logic [ID_BITS-1:0] id);
         slot_tab[s-1] = id;
         pos_tab[id] = s;
      endfunction

      function void swap(int a, int b);
         logic [ID_BITS-1:0] ia;
         logic [ID_BITS-1:0] ib;
         ia = slot_tab[a-1];
         ib = slot_tab[b-1];
         place(a, ib);
         place(b, ia);
      endfunction

      function void sift_up(int s);
         while (s > 1) begin
            if (key_in(s/2) > key_in(s)) return;
            swap(s, s/2);
            s = s/2;
         end
      endfunction

      function void sift_down(int s);
         int c;
         forever begin
            c = 2*s;
            if (c > count) return;
            if (c + 1 <= count && key_in(c+1) > key_in(c)) c = c + 1;
            if (!(key_in(c) > key_in(s))) return;
            swap(s, c);
            s = c;
         end
      endfunction

      function void note_request(logic [1:0] op, logic [ID_BITS-1:0] id,
                                 logic [KEY_BITS-1:0] key);
         heap_rsp_type r;
         logic [ID_BITS-1:0] top;
         logic [ID_BITS-1:0] last;
         r.id = id;
         r.key = '0;
         r.status = ST_OK;
         if (op == OP_PUSH) begin
            if (count >= MAX_IDS) begin
               r.status = ST_FULL;
               r.key = key_tab[id];
            end else if (pos_tab[id] != 0) begin
               r.status = ST_PRESENT;
               r.key = key_tab[id];
            end else begin
               key_tab[id] = key;
               count++;
               place(count, id);
               sift_up(count);
               r.key = key;
            end
         end else if (op == OP_POP) begin
            if (count == 0) begin
               r.status = ST_EMPTY;
               r.id = '0;
            end else begin
               top = slot_tab[0];
               r.id = top;
               r.key = key_tab[top];
               pos_tab[top] = 0;
               if (count > 1) begin
                  last = slot_tab[count-1];
                  count--;
                  place(1, last);
                  sift_down(1);
               end else count = 0;
            end
         end else if (op == OP_CHANGE) begin
            key_tab[id] = key;
            r.key = key;
            if (pos_tab[id] != 0) sift_down(pos_tab[id]);
         end
         r.entries = count[SLOT_BITS-1:0];
         pending.push_back(r);
      endfunction

      function void check_response(heap_rsp_type got);
         heap_rsp_type exp;
         checked++;
         if (pending.size() == 0) begin
            $error("unexpected response id=%0d", got.id);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.id !== exp.id) begin
            $error("out_id: expected %0d, got %0d", exp.id, got.id); errors++;
         end
         if (got.key !== exp.key) begin
            $error("out_key: expected %0h, got %0h", exp.key, got.key); errors++;
         end
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
         end
         if (got.entries !== exp.entries) begin
            $error("entries: expected %0d, got %0d", exp.entries, got.entries);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   imh_req_if req_ch ();
   imh_rsp_if rsp_ch ();

   indexed_max_heap dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   heap_scoreboard sb;
   int  cycles;
   bit  stall_mode;   // 0 random stalls, 1 no random stalls
   int  hold_off;
   int  sent;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      sb = new();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_PUSH;
      req_ch.item_id = '0;
      req_ch.item_key = '0;
      rsp_ch.ready = 1'b0;
      stall_mode = 1'b0;
      hold_off = 0;
      cycles = 0;
      sent = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off when asked
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response({rsp_ch.out_id, rsp_ch.out_key, rsp_ch.status,
                               rsp_ch.entries});
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ch.ready <= 1'b0;
         end else
            rsp_ch.ready <= stall_mode ? 1'b1 : ($urandom_range(99) >= 33);
      end
   end

   task automatic send(logic [1:0] op, logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key);
      if (!stall_mode)
         while ($urandom_range(99) < 33) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.item_id <= id;
      req_ch.item_key <= key;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(op, id, key);
      sent++;
   endtask

   task automatic idle_wait();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [KEY_BITS-1:0] rand_key();
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: return '1 - $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   // change key of a never-written id is fine; it writes the key
   task automatic random_request(int id_span);
      int r;
      logic [ID_BITS-1:0] id;
      r = $urandom_range(99);
      id = ID_BITS'($urandom_range(id_span - 1));
      if (r < 50) send(OP_PUSH, id, rand_key());
      else if (r < 80) send(OP_POP, ID_BITS'($urandom), $urandom);
      else if (r < 97) send(OP_CHANGE, id, rand_key());
      else send(OP_UNUSED, ID_BITS'($urandom), $urandom);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed
      send(OP_POP, 10'h3ff, '1);
      send(OP_PUSH, 10'd0, 32'd0);
      send(OP_PUSH, 10'h3ff, '1);
      send(OP_PUSH, 10'd5, 32'd100);
      send(OP_PUSH, 10'd6, 32'd100);
      send(OP_PUSH, 10'd7, 32'd100);
      send(OP_PUSH, 10'd5, 32'd9);
      send(OP_CHANGE, 10'h3ff, 32'd50);
      send(OP_CHANGE, 10'd300, 32'h5555_aaaa);
      send(OP_PUSH, 10'd300, 32'h1234);
      send(OP_UNUSED, 10'h2aa, 32'hffff_0000);
      send(OP_CHANGE, 10'd6, 32'd1);
      repeat (8) send(OP_POP, ID_BITS'($urandom), $urandom);
      idle_wait();
      // fill to full, probe full, key changes, partial drain
      stall_mode = 1'b1;
      for (int i = 0; i < MAX_IDS; i++) send(OP_PUSH, ID_BITS'(i), rand_key());
      send(OP_PUSH, 10'd17, 32'd3);
      for (int i = 0; i < 40; i++) send(OP_CHANGE, ID_BITS'($urandom), rand_key());
      for (int i = 0; i < 640; i++) send(OP_POP, '0, '0);
      idle_wait();
      // back-pressure: receiver holds off, sender keeps pushing
      hold_off = 300;
      for (int i = 0; i < 30; i++) send(OP_PUSH, ID_BITS'($urandom), rand_key());
      idle_wait();
      stall_mode = 1'b0;
      for (int i = 0; i < 195; i++) random_request(i < 100 ? 32 : 1024);
      idle_wait();
      $display("Ran %0d requests (%0d responses): directed cases, fill to full,", sent,
               sb.checked);
      $display("a long drain, a held-off receiver and random push/pop/change traffic.");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> indexed_max_heap.f
hw/rtl/imh_pkg.sv
hw/rtl/imh_if.sv
hw/rtl/indexed_max_heap.sv
hw/rtl/imh_checker.sv
tb/sv/indexed_max_heap_tb.sv
